@@ hdl/chxy_pkg.sv @@
// shared types, constants and angle table for the compass heading unit
// no dependencies; imported by every module of the unit
package chxy_pkg;

	// field widths
	localparam int IN_W  = 16;
	localparam int DEG_W = 9;

	// default settings of the top-level parameters
	localparam int DEF_CORDIC_STAGES   = 16;
	localparam int DEF_ANGLE_FRAC_BITS = 16;

	// datapath: magnitudes up to 2^15 shifted by the guard bits, gain below 2.4
	localparam int GUARD_BITS = 20;
	localparam int DP_W       = IN_W + GUARD_BITS + 3;

	// angle table: atan(2^-i) in degrees at 24 fraction bits
	localparam int TABLE_LEN  = 24;
	localparam int TABLE_FRAC = 24;
	localparam int TAB_W      = 30;

	localparam logic [TAB_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
		30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
		30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
		30'd234684,    30'd117342,    30'd58671,     30'd29335,
		30'd14668,     30'd7334,      30'd3667,      30'd1833,
		30'd917,       30'd458,       30'd229,       30'd115
	};

	// heading constants in whole degrees
	localparam int RIGHT_DEG = 90;
	localparam int HALF_DEG  = 45;
	localparam int PI_DEG    = 180;
	localparam logic [DEG_W-1:0] FULL_TURN = 9'd360;

	// reset values of the hard-iron offsets
	localparam logic [IN_W-1:0] X_OFFSET_RST = 16'hFF2B;
	localparam logic [IN_W-1:0] Y_OFFSET_RST = 16'h00FB;

	// configuration register indexes
	localparam logic REG_X_OFFSET = 1'b0;
	localparam logic REG_Y_OFFSET = 1'b1;

	// first-quadrant angles decided without the cordic
	typedef enum logic [1:0] {
		SPEC_NONE,
		SPEC_ZERO,
		SPEC_RIGHT,
		SPEC_HALF
	} spec_t;

	// quadrant and special-case info that rides alongside the datapath
	typedef struct packed {
		logic  x_neg;
		logic  y_neg;
		spec_t spec;
	} side_t;

	// table entry rounded half up to frac fraction bits
	function automatic logic [TAB_W-1:0] atan_step(input int idx, input int frac);
		logic [TAB_W:0] t;
		t = {ATAN_TAB[idx], 1'b0} >> (TABLE_FRAC - frac);
		t = t + 31'd1;
		return t[TAB_W:1];
	endfunction

endpackage

@@ hdl/chxy_prep.sv @@
// input side: hard-iron offset add, magnitudes, quadrant and special cases
// two pipeline stages; depends on chxy_pkg
module chxy_prep import chxy_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_stall,
	input  logic signed [IN_W-1:0] raw_x,
	input  logic signed [IN_W-1:0] raw_y,
	input  logic        [IN_W-1:0] x_offset,
	input  logic        [IN_W-1:0] y_offset,
	output logic                   dn_valid,
	input  logic                   dn_stall,
	output logic signed [DP_W-1:0] xs,
	output logic signed [DP_W-1:0] ys,
	output side_t                  side
);

	logic                   valid_s1;
	logic signed [IN_W-1:0] x_s1;
	logic signed [IN_W-1:0] y_s1;
	logic                   stall_s1;

	logic                   valid_s2;
	logic signed [DP_W-1:0] xs_s2;
	logic signed [DP_W-1:0] ys_s2;
	side_t                  side_s2;
	logic                   stall_s2;

	logic [IN_W-1:0] ax;
	logic [IN_W-1:0] ay;
	spec_t           spec;

	// a stage holds only when it is full and the next one holds
	assign stall_s2 = valid_s2 && dn_stall;
	assign stall_s1 = valid_s1 && stall_s2;
	assign up_stall = stall_s1;

	// stage 1: offset add, wraps to 16 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && up_valid) begin
			x_s1 <= raw_x + signed'(x_offset);
			y_s1 <= raw_y + signed'(y_offset);
		end
	end

	// magnitudes; the most negative value gives 2^15, which still fits unsigned
	assign ax = x_s1[IN_W-1] ? IN_W'(-x_s1) : IN_W'(x_s1);
	assign ay = y_s1[IN_W-1] ? IN_W'(-y_s1) : IN_W'(y_s1);

	// angles the cordic does not need to compute
	always_comb begin
		if (ay == '0) begin
			spec = SPEC_ZERO;
		end else if (ax == '0) begin
			spec = SPEC_RIGHT;
		end else if (ax == ay) begin
			spec = SPEC_HALF;
		end else begin
			spec = SPEC_NONE;
		end
	end

	// stage 2: scaled magnitudes and side info
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2 && valid_s1) begin
			xs_s2         <= signed'(DP_W'(ax) << GUARD_BITS);
			ys_s2         <= signed'(DP_W'(ay) << GUARD_BITS);
			side_s2.x_neg <= x_s1[IN_W-1];
			side_s2.y_neg <= y_s1[IN_W-1];
			side_s2.spec  <= spec;
		end
	end

	assign dn_valid = valid_s2;
	assign xs       = xs_s2;
	assign ys       = ys_s2;
	assign side     = side_s2;

	// a normal case always enters the cordic with both magnitudes nonzero
	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && side_s2.spec == SPEC_NONE |-> xs_s2 > 0 && ys_s2 > 0)
		else $error("cordic entry with zero magnitude");

endmodule

@@ hdl/chxy_cstage.sv @@
// one vectoring cordic iteration with its pipeline register
// depends on chxy_pkg for widths and the angle table
module chxy_cstage import chxy_pkg::*; #(
	parameter int SHIFT           = 0,
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  up_valid,
	output logic                                  up_stall,
	input  logic signed [DP_W-1:0]                xs_in,
	input  logic signed [DP_W-1:0]                ys_in,
	input  logic signed [ANGLE_FRAC_BITS+9:0]     z_in,
	input  side_t                                 side_in,
	output logic                                  dn_valid,
	input  logic                                  dn_stall,
	output logic signed [DP_W-1:0]                xs_out,
	output logic signed [DP_W-1:0]                ys_out,
	output logic signed [ANGLE_FRAC_BITS+9:0]     z_out,
	output side_t                                 side_out
);

	localparam int Z_W = ANGLE_FRAC_BITS + 10;
	localparam logic [TAB_W-1:0] STEP_RAW = atan_step(SHIFT, ANGLE_FRAC_BITS);
	localparam logic signed [Z_W-1:0] STEP = Z_W'(signed'({1'b0, STEP_RAW}));

	logic                   valid_s1;
	logic signed [DP_W-1:0] xs_s1;
	logic signed [DP_W-1:0] ys_s1;
	logic signed [Z_W-1:0]  z_s1;
	side_t                  side_s1;

	logic signed [DP_W-1:0] dx;
	logic signed [DP_W-1:0] dy;

	assign up_stall = valid_s1 && dn_stall;

	// floor shifts of the cross terms
	assign dx = ys_in >>> SHIFT;
	assign dy = xs_in >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	// rotate toward the x axis and track the angle
	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			if (!ys_in[DP_W-1]) begin
				xs_s1 <= xs_in + dx;
				ys_s1 <= ys_in - dy;
				z_s1  <= z_in + STEP;
			end else begin
				xs_s1 <= xs_in - dx;
				ys_s1 <= ys_in + dy;
				z_s1  <= z_in - STEP;
			end
			side_s1 <= side_in;
		end
	end

	assign dn_valid = valid_s1;
	assign xs_out   = xs_s1;
	assign ys_out   = ys_s1;
	assign z_out    = z_s1;
	assign side_out = side_s1;

endmodule

@@ hdl/chxy_finish.sv @@
// output side: clamp, special-case angles, quadrant fix and whole degrees
// two pipeline stages; depends on chxy_pkg
module chxy_finish import chxy_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              up_valid,
	output logic                              up_stall,
	input  logic signed [ANGLE_FRAC_BITS+9:0] z_in,
	input  side_t                             side_in,
	output logic                              dn_valid,
	input  logic                              dn_stall,
	output logic        [DEG_W-1:0]           heading
);

	localparam int Z_W  = ANGLE_FRAC_BITS + 10;
	localparam int TH_W = ANGLE_FRAC_BITS + 7;
	localparam int H_W  = ANGLE_FRAC_BITS + DEG_W;
	localparam logic signed [Z_W-1:0] RIGHT_Z = Z_W'(RIGHT_DEG) <<< ANGLE_FRAC_BITS;
	localparam logic [TH_W-1:0] RIGHT_TH = TH_W'(RIGHT_DEG) << ANGLE_FRAC_BITS;
	localparam logic [TH_W-1:0] HALF_TH  = TH_W'(HALF_DEG) << ANGLE_FRAC_BITS;
	localparam logic [H_W-1:0]  PI_H     = H_W'(PI_DEG) << ANGLE_FRAC_BITS;

	logic                   valid_s1;
	logic [TH_W-1:0]        theta_s1;
	side_t                  side_s1;
	logic                   stall_s1;

	logic                   valid_s2;
	logic [DEG_W-1:0]       heading_s2;
	logic                   stall_s2;

	logic [TH_W-1:0]        theta;
	logic [H_W-1:0]         theta_h;
	logic [H_W-1:0]         h;
	logic [DEG_W-1:0]       deg;

	assign stall_s2 = valid_s2 && dn_stall;
	assign stall_s1 = valid_s1 && stall_s2;
	assign up_stall = stall_s1;

	// first-quadrant angle: special cases, else the cordic angle clamped to 0..90
	always_comb begin
		case (side_in.spec)
			SPEC_ZERO:  theta = '0;
			SPEC_RIGHT: theta = RIGHT_TH;
			SPEC_HALF:  theta = HALF_TH;
			SPEC_NONE: begin
				if (z_in[Z_W-1]) begin
					theta = '0;
				end else if (z_in > RIGHT_Z) begin
					theta = RIGHT_TH;
				end else begin
					theta = TH_W'(z_in);
				end
			end
			default:    theta = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && up_valid) begin
			theta_s1 <= theta;
			side_s1  <= side_in;
		end
	end

	// place the angle in its quadrant
	assign theta_h = H_W'(theta_s1);

	always_comb begin
		if (!side_s1.x_neg && !side_s1.y_neg) begin
			h = theta_h;
		end else if (side_s1.x_neg && !side_s1.y_neg) begin
			h = PI_H - theta_h;
		end else if (side_s1.x_neg) begin
			h = PI_H + theta_h;
		end else begin
			h = (PI_H << 1) - theta_h;
		end
	end

	// truncate to whole degrees, a full turn wraps to zero
	assign deg = h[H_W-1:ANGLE_FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2 && valid_s1) begin
			heading_s2 <= (deg >= FULL_TURN) ? '0 : deg;
		end
	end

	assign dn_valid = valid_s2;
	assign heading  = heading_s2;

	// equal magnitudes land on a diagonal
	a_diag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !stall_s2 && side_s1.spec == SPEC_HALF |=>
		heading_s2 == 9'd45 || heading_s2 == 9'd135 ||
		heading_s2 == 9'd225 || heading_s2 == 9'd315)
		else $error("diagonal case off the diagonal");

endmodule

@@ hdl/compass_heading_from_xy_unit.sv @@
// compass heading in whole degrees from one magnetometer x/y sample pair
// each request passes through the prep, cordic and finish stage registers in order
// throughput: one request per cycle while out_stall is low, set by one cordic iteration per stage
// each stage holds only while full and blocked, so bubbles close under stall
// reset clears all valid bits and loads the offsets with -213 and +251
// depends on chxy_pkg, chxy_prep, chxy_cstage, chxy_finish
module compass_heading_from_xy_unit import chxy_pkg::*; #(
	parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES,
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [IN_W-1:0] raw_x,
	input  logic signed [IN_W-1:0] raw_y,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic        [DEG_W-1:0] heading_deg,
	input  logic                   cfg_wr_en,
	input  logic                   cfg_index,
	input  logic        [IN_W-1:0] cfg_data
);

	localparam int Z_W = ANGLE_FRAC_BITS + 10;

	logic [IN_W-1:0] x_offset_q;
	logic [IN_W-1:0] y_offset_q;

	logic                   cv   [0:CORDIC_STAGES];
	logic                   cst  [0:CORDIC_STAGES];
	logic signed [DP_W-1:0] cx   [0:CORDIC_STAGES];
	logic signed [DP_W-1:0] cy   [0:CORDIC_STAGES];
	logic signed [Z_W-1:0]  cz   [0:CORDIC_STAGES];
	side_t                  cside[0:CORDIC_STAGES];

	// offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= X_OFFSET_RST;
			y_offset_q <= Y_OFFSET_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_X_OFFSET: x_offset_q <= cfg_data;
				REG_Y_OFFSET: y_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// offset add and magnitudes
	chxy_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_stall (in_stall),
		.raw_x    (raw_x),
		.raw_y    (raw_y),
		.x_offset (x_offset_q),
		.y_offset (y_offset_q),
		.dn_valid (cv[0]),
		.dn_stall (cst[0]),
		.xs       (cx[0]),
		.ys       (cy[0]),
		.side     (cside[0])
	);

	assign cz[0] = '0;

	// cordic iterations, one per stage
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		chxy_cstage #(
			.SHIFT           (k),
			.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cv[k]),
			.up_stall (cst[k]),
			.xs_in    (cx[k]),
			.ys_in    (cy[k]),
			.z_in     (cz[k]),
			.side_in  (cside[k]),
			.dn_valid (cv[k+1]),
			.dn_stall (cst[k+1]),
			.xs_out   (cx[k+1]),
			.ys_out   (cy[k+1]),
			.z_out    (cz[k+1]),
			.side_out (cside[k+1])
		);
	end

	// quadrant fix and whole degrees
	chxy_finish #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cv[CORDIC_STAGES]),
		.up_stall (cst[CORDIC_STAGES]),
		.z_in     (cz[CORDIC_STAGES]),
		.side_in  (cside[CORDIC_STAGES]),
		.dn_valid (out_valid),
		.dn_stall (out_stall),
		.heading  (heading_deg)
	);

	// heading stays within one turn
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading_deg < FULL_TURN)
		else $error("heading out of range");

	// requests are held off only when every stage up to the output is full
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	// a blocked result holds while its stall persists
	a_hold_first: assert property (@(posedge clk) disable iff (!arst_n)
		cv[0] && cst[0] |=> cv[0])
		else $error("first cordic entry lost under stall");

endmodule
